// ===== hw/rtl/amc_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Accumulator machine package
// Shared sizes, opcodes and request/result types of the accumulator machine.
// ----------------------------------------------------------------------------
package amc_pkg;

	localparam int PROG_WORDS = 128;
	localparam int PROG_AW    = $clog2(PROG_WORDS);
	localparam int DATA_WORDS = 16;
	localparam int DATA_AW    = $clog2(DATA_WORDS);
	localparam int ACC_W      = 32;
	localparam int OPC_W      = 4;
	localparam int OPD_W      = 7;

	localparam logic [PROG_AW-1:0] START_PC = PROG_AW'(10);

	localparam logic [OPC_W-1:0] OPC_NONE   = 4'd0;
	localparam logic [OPC_W-1:0] OPC_LOAD   = 4'd1;
	localparam logic [OPC_W-1:0] OPC_ADD    = 4'd2;
	localparam logic [OPC_W-1:0] OPC_STORE  = 4'd3;
	localparam logic [OPC_W-1:0] OPC_SUB    = 4'd4;
	localparam logic [OPC_W-1:0] OPC_INPUT  = 4'd5;
	localparam logic [OPC_W-1:0] OPC_OUTPUT = 4'd6;
	localparam logic [OPC_W-1:0] OPC_HALT   = 4'd7;
	localparam logic [OPC_W-1:0] OPC_JUMP   = 4'd8;
	localparam logic [OPC_W-1:0] OPC_SKIPZ  = 4'd9;

	localparam logic OP_WRITE = 1'b0;
	localparam logic OP_EXEC  = 1'b1;

	typedef struct packed {
		logic [OPC_W-1:0] opcode;
		logic [OPD_W-1:0] operand;
	} prog_word_t;

	typedef struct packed {
		logic                    en;
		logic [PROG_AW-1:0]      addr;
		prog_word_t              word;
	} prog_wr_t;

	typedef struct packed {
		logic                    op;
		logic [6:0]              prog_addr;
		logic [OPC_W-1:0]        prog_opcode;
		logic [OPD_W-1:0]        prog_operand;
		logic signed [ACC_W-1:0] input_value;
	} req_t;

	typedef struct packed {
		logic [6:0]              program_counter;
		logic signed [ACC_W-1:0] accumulator_value;
		logic                    output_strobe;
		logic                    halted_flag;
		logic [OPC_W-1:0]        executed_opcode;
	} res_t;

endpackage

// ===== hw/rtl/accumulator_machine_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Accumulator machine core
// Single-accumulator instruction machine driven by a request stream.
// ----------------------------------------------------------------------------
// Each request either writes one program word or executes one instruction,
// and produces exactly one result. The core takes one request per cycle
// while the result side is not stalled. A request is held in the input
// register, and its result is offered from the result register, which
// loads when it is free or the sink is ready. The program
// store is read ahead, at the counter value that the current
// instruction leaves, so a jump or skip does not stall the stream.
module accumulator_machine_core (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	// prog_addr [6:0], prog_opcode [10:7], prog_operand [17:11],
	// input_value [49:18], zero fill [55:50]
	input  logic [55:0] s_axis_tdata,
	// op [0]
	input  logic [0:0]  s_axis_tuser,
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	// program_counter [6:0], accumulator_value [38:7], output_strobe [39],
	// halted_flag [40], executed_opcode [44:41], zero fill [47:45]
	output logic [47:0] m_axis_tdata
);

	amc_pkg::req_t               req_s1;
	logic                        valid_s1;
	amc_pkg::res_t               res_q;
	logic                        out_valid_q;
	logic                        advance;
	amc_pkg::res_t               res;
	amc_pkg::prog_word_t         word;
	amc_pkg::prog_wr_t           wr;
	logic [amc_pkg::PROG_AW-1:0] pc_next;

	assign advance       = valid_s1 && (!out_valid_q || m_axis_tready);
	assign s_axis_tready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (s_axis_tready) begin
				valid_s1 <= s_axis_tvalid;
			end
			if (advance) begin
				out_valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tvalid && s_axis_tready) begin
			req_s1.op           <= s_axis_tuser[0];
			req_s1.prog_addr    <= s_axis_tdata[6:0];
			req_s1.prog_opcode  <= s_axis_tdata[10:7];
			req_s1.prog_operand <= s_axis_tdata[17:11];
			req_s1.input_value  <= s_axis_tdata[49:18];
		end
		if (advance) begin
			res_q <= res;
		end
	end

	always_comb begin
		wr.en           = advance && (req_s1.op == amc_pkg::OP_WRITE);
		wr.addr         = req_s1.prog_addr[amc_pkg::PROG_AW-1:0];
		wr.word.opcode  = req_s1.prog_opcode;
		wr.word.operand = req_s1.prog_operand;
	end

	amc_prog_mem u_prog_mem (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr      (wr),
		.rd_addr (pc_next),
		.rd_word (word)
	);

	amc_datapath u_datapath (
		.clk     (clk),
		.arst_n  (arst_n),
		.advance (advance),
		.req     (req_s1),
		.word    (word),
		.pc_next (pc_next),
		.res     (res)
	);

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {3'b000, res_q.executed_opcode, res_q.halted_flag,
		res_q.output_strobe, res_q.accumulator_value, res_q.program_counter};

endmodule

// ===== hw/rtl/amc_prog_mem.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Accumulator machine program store
// Program word memory with per-word valid bits and write-to-read forwarding.
// ----------------------------------------------------------------------------
module amc_prog_mem (
	input  logic                       clk,
	input  logic                       arst_n,
	input  amc_pkg::prog_wr_t          wr,
	input  logic [amc_pkg::PROG_AW-1:0] rd_addr,
	output amc_pkg::prog_word_t        rd_word
);

	amc_pkg::prog_word_t                  mem [amc_pkg::PROG_WORDS];
	logic [amc_pkg::PROG_WORDS-1:0]       valid_q;
	amc_pkg::prog_word_t                  rd_data_q;
	amc_pkg::prog_word_t                  fwd_word_q;
	logic                                 hit_q;
	logic                                 fwd_q;

	always_ff @(posedge clk) begin
		if (wr.en) begin
			mem[wr.addr] <= wr.word;
		end
		rd_data_q  <= mem[rd_addr];
		fwd_word_q <= wr.word;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
			hit_q   <= 1'b0;
			fwd_q   <= 1'b0;
		end else begin
			if (wr.en) begin
				valid_q[wr.addr] <= 1'b1;
			end
			hit_q <= valid_q[rd_addr];
			fwd_q <= wr.en && (wr.addr == rd_addr);
		end
	end

	always_comb begin
		if (fwd_q) begin
			rd_word = fwd_word_q;
		end else if (hit_q) begin
			rd_word = rd_data_q;
		end else begin
			rd_word = '0;
		end
	end

endmodule

// ===== hw/rtl/amc_datapath.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Accumulator machine datapath
// Architectural state, data store and combinational instruction execution.
// ----------------------------------------------------------------------------
module amc_datapath (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        advance,
	input  amc_pkg::req_t               req,
	input  amc_pkg::prog_word_t         word,
	output logic [amc_pkg::PROG_AW-1:0] pc_next,
	output amc_pkg::res_t               res
);

	logic [amc_pkg::PROG_AW-1:0] pc_q;
	logic [amc_pkg::ACC_W-1:0]   acc_q;
	logic                        halted_q;
	logic [amc_pkg::ACC_W-1:0]   data_q [amc_pkg::DATA_WORDS];

	logic [amc_pkg::PROG_AW-1:0] pc_n;
	logic [amc_pkg::ACC_W-1:0]   acc_n;
	logic                        halted_n;
	logic                        strobe;
	logic [amc_pkg::OPC_W-1:0]   executed;
	logic                        dwr_en;
	logic [amc_pkg::DATA_AW-1:0] da;
	logic [amc_pkg::ACC_W-1:0]   dval;

	assign da   = word.operand[amc_pkg::DATA_AW-1:0];
	assign dval = data_q[da];

	always_comb begin
		pc_n     = pc_q;
		acc_n    = acc_q;
		halted_n = halted_q;
		strobe   = 1'b0;
		executed = amc_pkg::OPC_NONE;
		dwr_en   = 1'b0;
		if (req.op == amc_pkg::OP_EXEC && !halted_q) begin
			pc_n     = pc_q + amc_pkg::PROG_AW'(1);
			executed = word.opcode;
			unique case (word.opcode)
				amc_pkg::OPC_LOAD:   acc_n = dval;
				amc_pkg::OPC_ADD:    acc_n = acc_q + dval;
				amc_pkg::OPC_STORE:  dwr_en = 1'b1;
				amc_pkg::OPC_SUB:    acc_n = acc_q - dval;
				amc_pkg::OPC_INPUT:  acc_n = req.input_value;
				amc_pkg::OPC_OUTPUT: strobe = 1'b1;
				amc_pkg::OPC_HALT:   halted_n = 1'b1;
				amc_pkg::OPC_JUMP:   pc_n = word.operand[amc_pkg::PROG_AW-1:0];
				amc_pkg::OPC_SKIPZ: begin
					if (acc_q == '0) begin
						pc_n = pc_q + amc_pkg::PROG_AW'(2);
					end
				end
				default: ;
			endcase
		end
	end

	assign pc_next = advance ? pc_n : pc_q;

	always_comb begin
		res.program_counter   = 7'(pc_n);
		res.accumulator_value = acc_n;
		res.output_strobe     = strobe;
		res.halted_flag       = halted_n;
		res.executed_opcode   = executed;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q     <= amc_pkg::START_PC;
			acc_q    <= '0;
			halted_q <= 1'b0;
			for (int i = 0; i < amc_pkg::DATA_WORDS; i++) begin
				data_q[i] <= '0;
			end
		end else if (advance) begin
			pc_q     <= pc_n;
			acc_q    <= acc_n;
			halted_q <= halted_n;
			if (dwr_en) begin
				data_q[da] <= acc_q;
			end
		end
	end

endmodule

// ===== verif/accumulator_machine_core_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Accumulator machine core testbench
// Drives write and execute requests into the core, with random idle bursts
// on both stream sides, and checks every result against a cycle-free
// predictor of the machine. A short directed table covers every opcode,
// the arithmetic extremes, address wrapping and the halt behavior. The
// random part writes short programs at the live program counter and then
// runs them. Halt is sticky, so the halt rows run only at the very end.
// ----------------------------------------------------------------------------
module accumulator_machine_core_tb;

	localparam int RANDOM_ITEMS = 1700;
	localparam int QUIET_ITEMS  = 150;
	localparam int DRAIN_AT     = 800;
	localparam int STALL_LIMIT  = 1000;

	typedef struct packed {
		logic [amc_pkg::PROG_AW-1:0] pc;
		logic [amc_pkg::ACC_W-1:0]   acc;
		logic                        strobe;
		logic                        halted;
		logic [amc_pkg::OPC_W-1:0]   opcode;
	} step_result_t;

	typedef struct {
		amc_pkg::req_t req;
		bit            at_pc;
		bit            typed;
		step_result_t  want;
	} stim_row_t;

	localparam step_result_t NO_CHECK = '0;

	logic        clk = 1'b0;
	logic        arst_n;
	logic        s_axis_tvalid;
	logic        s_axis_tready;
	logic [55:0] s_axis_tdata;
	logic [0:0]  s_axis_tuser;
	logic        m_axis_tvalid;
	logic        m_axis_tready;
	logic [47:0] m_axis_tdata;

	logic [amc_pkg::OPC_W+amc_pkg::OPD_W-1:0] code_mem [amc_pkg::PROG_WORDS];
	logic [amc_pkg::ACC_W-1:0]                data_mem [amc_pkg::DATA_WORDS];
	logic [amc_pkg::PROG_AW-1:0]              m_pc;
	logic [amc_pkg::ACC_W-1:0]                m_acc;
	logic                                     m_halted;

	step_result_t pending_results [$];
	stim_row_t    rows [$];
	int           items_sent = 0;
	int           fail_count = 0;
	int           idle_count = 0;
	bit           quiet = 1'b0;

	accumulator_machine_core u_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata (s_axis_tdata),
		.s_axis_tuser (s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata (m_axis_tdata)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic step_result_t machine_step(amc_pkg::req_t r);
		logic [amc_pkg::OPC_W-1:0]   opc;
		logic [amc_pkg::OPD_W-1:0]   opd;
		logic [amc_pkg::DATA_AW-1:0] da;
		step_result_t                res;
		res.strobe = 1'b0;
		res.opcode = amc_pkg::OPC_NONE;
		if (r.op == amc_pkg::OP_WRITE) begin
			code_mem[r.prog_addr] = {r.prog_opcode, r.prog_operand};
		end else if (!m_halted) begin
			{opc, opd} = code_mem[m_pc];
			da = opd[amc_pkg::DATA_AW-1:0];
			m_pc = m_pc + amc_pkg::PROG_AW'(1);
			res.opcode = opc;
			case (opc)
				amc_pkg::OPC_LOAD: m_acc = data_mem[da];
				amc_pkg::OPC_ADD: m_acc = m_acc + data_mem[da];
				amc_pkg::OPC_STORE: data_mem[da] = m_acc;
				amc_pkg::OPC_SUB: m_acc = m_acc - data_mem[da];
				amc_pkg::OPC_INPUT: m_acc = r.input_value;
				amc_pkg::OPC_OUTPUT: res.strobe = 1'b1;
				amc_pkg::OPC_HALT: m_halted = 1'b1;
				amc_pkg::OPC_JUMP: m_pc = amc_pkg::PROG_AW'(opd);
				amc_pkg::OPC_SKIPZ: begin
					if (m_acc == '0) m_pc = m_pc + amc_pkg::PROG_AW'(1);
				end
				default: ;
			endcase
		end
		res.pc = m_pc;
		res.acc = m_acc;
		res.halted = m_halted;
		return res;
	endfunction

	function automatic logic [amc_pkg::ACC_W-1:0] pick_value();
		case ($urandom_range(0, 7))
			0, 1: return '0;
			2: return '1;
			3: return $urandom_range(0, 1) ? 32'h8000_0000 : 32'h7fff_ffff;
			default: return $urandom;
		endcase
	endfunction

	function automatic logic [amc_pkg::OPC_W-1:0] pick_opcode();
		logic [amc_pkg::OPC_W-1:0] opc;
		do begin
			opc = ($urandom_range(0, 3) == 0) ? amc_pkg::OPC_W'($urandom_range(0, 15))
				: amc_pkg::OPC_W'($urandom_range(1, 9));
		end while (opc == amc_pkg::OPC_HALT);
		return opc;
	endfunction

	function automatic void add_row(logic op, logic [6:0] addr,
			logic [amc_pkg::OPC_W-1:0] opc, logic [amc_pkg::OPD_W-1:0] opd,
			logic [amc_pkg::ACC_W-1:0] val, bit typed, step_result_t want, bit at_pc);
		stim_row_t row;
		row.req = '{op, addr, opc, opd, val};
		row.at_pc = at_pc;
		row.typed = typed;
		row.want = want;
		rows.push_back(row);
	endfunction

	function automatic void check_field(string what, logic [amc_pkg::ACC_W-1:0] want,
			logic [amc_pkg::ACC_W-1:0] got);
		if (got !== want) begin
			fail_count++;
			$display("%0t: %s mismatch, expected %h, actual %h", $time, what, want, got);
		end
	endfunction

	task automatic send_request(amc_pkg::req_t r, bit typed, step_result_t want);
		step_result_t predicted;
		if (!quiet && $urandom_range(0, 3) == 0) begin
			@(negedge clk);
			s_axis_tvalid <= 1'b0;
			repeat ($urandom_range(1, 14) - 1) @(negedge clk);
		end
		@(negedge clk);
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= {6'b0, r.input_value, r.prog_operand, r.prog_opcode, r.prog_addr};
		s_axis_tuser <= r.op;
		do @(posedge clk); while (!s_axis_tready);
		predicted = machine_step(r);
		pending_results.push_back(typed ? want : predicted);
		items_sent++;
	endtask

	task automatic run_rows(int first, int last);
		amc_pkg::req_t r;
		for (int i = first; i <= last; i++) begin
			r = rows[i].req;
			if (rows[i].at_pc) r.prog_addr = m_pc;
			send_request(r, rows[i].typed, rows[i].want);
		end
	endtask

	initial begin
		int hold;
		m_axis_tready = 1'b0;
		hold = 0;
		forever begin
			@(negedge clk);
			if (quiet) begin
				m_axis_tready <= 1'b1;
				hold = 0;
			end else if (hold > 0) begin
				hold--;
			end else if ($urandom_range(0, 3) == 0) begin
				m_axis_tready <= 1'b0;
				hold = $urandom_range(1, 14) - 1;
			end else begin
				m_axis_tready <= 1'b1;
				hold = $urandom_range(1, 20) - 1;
			end
		end
	end

	always @(posedge clk) begin
		step_result_t got;
		step_result_t want;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			got.pc = m_axis_tdata[6:0];
			got.acc = m_axis_tdata[38:7];
			got.strobe = m_axis_tdata[39];
			got.halted = m_axis_tdata[40];
			got.opcode = m_axis_tdata[44:41];
			if (pending_results.size() == 0) begin
				fail_count++;
				$display("%0t: result with no pending request, expected none, actual %h",
					$time, got);
			end else begin
				want = pending_results.pop_front();
				check_field("program_counter", amc_pkg::ACC_W'(want.pc),
					amc_pkg::ACC_W'(got.pc));
				check_field("accumulator_value", want.acc, got.acc);
				check_field("output_strobe", amc_pkg::ACC_W'(want.strobe),
					amc_pkg::ACC_W'(got.strobe));
				check_field("halted_flag", amc_pkg::ACC_W'(want.halted),
					amc_pkg::ACC_W'(got.halted));
				check_field("executed_opcode", amc_pkg::ACC_W'(want.opcode),
					amc_pkg::ACC_W'(got.opcode));
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
				idle_count <= 0;
			end else if (idle_count >= STALL_LIMIT) begin
				$display("%0t: no request or result moved for %0d cycles", $time, idle_count);
				$display("FAILED: results differ");
				$finish;
			end else begin
				idle_count <= idle_count + 1;
			end
		end
	end

	initial begin
		amc_pkg::req_t r;
		int            tail_start;
		int            seg_len;
		int            base;
		bit            drained;
		arst_n = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata = '0;
		s_axis_tuser = '0;
		drained = 1'b0;
		for (int i = 0; i < amc_pkg::PROG_WORDS; i++) code_mem[i] = '0;
		for (int i = 0; i < amc_pkg::DATA_WORDS; i++) data_mem[i] = '0;
		m_pc = amc_pkg::START_PC;
		m_acc = '0;
		m_halted = 1'b0;

		// Program after the start address, then walk it: overflow on add, operands
		// past the data store, a taken skip, a jump near the top and a counter wrap.
		add_row(amc_pkg::OP_EXEC, 7'd0, amc_pkg::OPC_NONE, 7'd0, 32'd0, 1'b1,
			'{7'd11, 32'd0, 1'b0, 1'b0, amc_pkg::OPC_NONE}, 1'b0);
		add_row(amc_pkg::OP_WRITE, 7'd11, amc_pkg::OPC_INPUT, 7'd0, 32'd0, 1'b0,
			NO_CHECK, 1'b0);
		add_row(amc_pkg::OP_WRITE, 7'd12, amc_pkg::OPC_STORE, 7'd127, 32'd0, 1'b0,
			NO_CHECK, 1'b0);
		add_row(amc_pkg::OP_WRITE, 7'd13, amc_pkg::OPC_ADD, 7'd31, 32'd0, 1'b0,
			NO_CHECK, 1'b0);
		add_row(amc_pkg::OP_WRITE, 7'd14, amc_pkg::OPC_OUTPUT, 7'd0, 32'd0, 1'b0,
			NO_CHECK, 1'b0);
		add_row(amc_pkg::OP_WRITE, 7'd15, amc_pkg::OPC_SUB, 7'd15, 32'd0, 1'b0,
			NO_CHECK, 1'b0);
		add_row(amc_pkg::OP_WRITE, 7'd16, amc_pkg::OPC_LOAD, 7'd64, 32'd0, 1'b0,
			NO_CHECK, 1'b0);
		add_row(amc_pkg::OP_WRITE, 7'd17, amc_pkg::OPC_SKIPZ, 7'd0, 32'd0, 1'b0,
			NO_CHECK, 1'b0);
		add_row(amc_pkg::OP_WRITE, 7'd19, amc_pkg::OPC_JUMP, 7'd126, 32'd0, 1'b0,
			NO_CHECK, 1'b0);
		add_row(amc_pkg::OP_WRITE, 7'd126, amc_pkg::OPC_INPUT, 7'd0, 32'd0, 1'b0,
			NO_CHECK, 1'b0);
		add_row(amc_pkg::OP_WRITE, 7'd127, amc_pkg::OPC_SKIPZ, 7'd0, 32'd0, 1'b0,
			NO_CHECK, 1'b0);
		add_row(amc_pkg::OP_EXEC, 7'd0, amc_pkg::OPC_NONE, 7'd0, 32'h7fff_ffff, 1'b1,
			'{7'd12, 32'h7fff_ffff, 1'b0, 1'b0, amc_pkg::OPC_INPUT}, 1'b0);
		add_row(amc_pkg::OP_EXEC, 7'd0, amc_pkg::OPC_NONE, 7'd0, 32'd0, 1'b0,
			NO_CHECK, 1'b0);
		add_row(amc_pkg::OP_EXEC, 7'd0, amc_pkg::OPC_NONE, 7'd0, 32'd0, 1'b1,
			'{7'd14, 32'hffff_fffe, 1'b0, 1'b0, amc_pkg::OPC_ADD}, 1'b0);
		add_row(amc_pkg::OP_EXEC, 7'd0, amc_pkg::OPC_NONE, 7'd0, 32'd0, 1'b1,
			'{7'd15, 32'hffff_fffe, 1'b1, 1'b0, amc_pkg::OPC_OUTPUT}, 1'b0);
		add_row(amc_pkg::OP_EXEC, 7'd0, amc_pkg::OPC_NONE, 7'd0, 32'd0, 1'b0,
			NO_CHECK, 1'b0);
		add_row(amc_pkg::OP_EXEC, 7'd0, amc_pkg::OPC_NONE, 7'd0, 32'd0, 1'b0,
			NO_CHECK, 1'b0);
		add_row(amc_pkg::OP_EXEC, 7'd0, amc_pkg::OPC_NONE, 7'd0, 32'd0, 1'b0,
			NO_CHECK, 1'b0);
		add_row(amc_pkg::OP_EXEC, 7'd0, amc_pkg::OPC_NONE, 7'd0, 32'd0, 1'b0,
			NO_CHECK, 1'b0);
		add_row(amc_pkg::OP_EXEC, 7'd0, amc_pkg::OPC_NONE, 7'd0, 32'h8000_0000, 1'b1,
			'{7'd127, 32'h8000_0000, 1'b0, 1'b0, amc_pkg::OPC_INPUT}, 1'b0);
		add_row(amc_pkg::OP_EXEC, 7'd0, amc_pkg::OPC_NONE, 7'd0, 32'd0, 1'b1,
			'{7'd0, 32'h8000_0000, 1'b0, 1'b0, amc_pkg::OPC_SKIPZ}, 1'b0);
		add_row(amc_pkg::OP_WRITE, 7'd0, 4'd15, 7'd127, 32'hffff_ffff, 1'b0,
			NO_CHECK, 1'b0);
		add_row(amc_pkg::OP_EXEC, 7'd0, amc_pkg::OPC_NONE, 7'd0, 32'd0, 1'b1,
			'{7'd1, 32'h8000_0000, 1'b0, 1'b0, 4'd15}, 1'b0);
		tail_start = rows.size();
		add_row(amc_pkg::OP_WRITE, 7'd0, amc_pkg::OPC_HALT, 7'd0, 32'd0, 1'b0,
			NO_CHECK, 1'b1);
		add_row(amc_pkg::OP_EXEC, 7'd0, amc_pkg::OPC_NONE, 7'd0, 32'd0, 1'b0,
			NO_CHECK, 1'b0);
		add_row(amc_pkg::OP_EXEC, 7'd0, amc_pkg::OPC_NONE, 7'd0, 32'd0, 1'b0,
			NO_CHECK, 1'b0);
		add_row(amc_pkg::OP_WRITE, 7'd0, amc_pkg::OPC_INPUT, 7'd0, 32'd0, 1'b0,
			NO_CHECK, 1'b1);
		add_row(amc_pkg::OP_EXEC, 7'd0, amc_pkg::OPC_NONE, 7'd0, 32'h1234_5678, 1'b0,
			NO_CHECK, 1'b0);

		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		run_rows(0, tail_start - 1);

		while (items_sent < RANDOM_ITEMS) begin
			quiet = (items_sent >= RANDOM_ITEMS - QUIET_ITEMS);
			if (!drained && items_sent >= DRAIN_AT) begin
				drained = 1'b1;
				@(negedge clk);
				s_axis_tvalid <= 1'b0;
				while (pending_results.size() != 0) @(negedge clk);
			end
			if ($urandom_range(0, 9) < 8) begin
				seg_len = $urandom_range(2, 10);
				base = int'(m_pc);
				for (int i = 0; i < seg_len; i++) begin
					r.op = amc_pkg::OP_WRITE;
					r.prog_addr = 7'(base + i);
					r.prog_opcode = pick_opcode();
					r.prog_operand = 7'($urandom);
					if (r.prog_opcode == amc_pkg::OPC_JUMP && $urandom_range(0, 1))
						r.prog_operand = 7'(base + $urandom_range(0, seg_len - 1));
					r.input_value = $urandom;
					send_request(r, 1'b0, NO_CHECK);
				end
				repeat ($urandom_range(seg_len, 2 * seg_len)) begin
					r.op = amc_pkg::OP_EXEC;
					r.prog_addr = 7'($urandom);
					r.prog_opcode = 4'($urandom);
					r.prog_operand = 7'($urandom);
					r.input_value = pick_value();
					send_request(r, 1'b0, NO_CHECK);
				end
			end else begin
				repeat ($urandom_range(1, 6)) begin
					r.op = 1'($urandom_range(0, 1));
					r.prog_addr = 7'($urandom);
					r.prog_opcode = pick_opcode();
					r.prog_operand = 7'($urandom);
					r.input_value = pick_value();
					send_request(r, 1'b0, NO_CHECK);
				end
			end
		end

		quiet = 1'b1;
		run_rows(tail_start, rows.size() - 1);
		@(negedge clk);
		s_axis_tvalid <= 1'b0;
		while (pending_results.size() != 0) @(posedge clk);
		repeat (8) @(posedge clk);
		if (fail_count == 0) begin
			$display("PASSED: all results match");
		end else begin
			$display("FAILED: results differ");
		end
		$finish;
	end

endmodule
